// ===== sv/pidsi_pkg.sv =====
// ----------------------------------------------------------------------------
// pidsi_pkg
// Shared types and constants for the shaped-integral PID controller.
// ----------------------------------------------------------------------------
package pidsi_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int INT_W      = 48;
   localparam int RATIO_W    = 16;
   localparam int GAIN_W     = 31;
   localparam int CSR_W      = 63;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_STEPS  = RATIO_W;
   localparam int NUM_TERMS  = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_DT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_RATE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KF        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ILIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATE  = 3'd7;

   // request codes
   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // term selects
   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;
   localparam logic [1:0] TERM_F = 2'd3;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] target;
      logic signed [DATA_W-1:0] measured;
      logic signed [INT_W-1:0]  integral_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic signed [DATA_W-1:0] effective_target;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ERR, S_DZ, S_RATIO, S_DIV, S_PROD, S_INC,
      S_MAG, S_MLO, S_MHI, S_TERM, S_ACC, S_FIN, S_LOAD, S_OUT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       do_err;
      logic       do_dz;
      logic       do_ratio;
      logic       div_step;
      logic       do_prod;
      logic       do_inc;
      logic       do_mag;
      logic       do_mlo;
      logic       do_mhi;
      logic       do_term;
      logic       do_acc;
      logic       do_fin;
      logic       do_load;
      logic [1:0] term_sel;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic need_div;
   } status_type;

endpackage

// ===== sv/pid_controller_shaped_integral_top.sv =====
// ----------------------------------------------------------------------------
// A control step runs error, dead zone, ratio, product and increment, then the
// four gain terms and the final clamp; the ratio uses a 16-step divider when the
// integral rate falls inside the ramp. A load goes straight to its result.
// Throughput: one item at a time; a new transfer is taken once the result is.
// Reset (synchronous) clears configuration, integral store and history to zero.
// ----------------------------------------------------------------------------
// pid_controller_shaped_integral_top
// Fixed-point PID with variable-speed integral: sequencer plus datapath.
// ----------------------------------------------------------------------------
module pid_controller_shaped_integral_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write,
   input  logic [pidsi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pidsi_pkg::CSR_W-1:0]       csr_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pidsi_pkg::req_payload_type        req_payload,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pidsi_pkg::rsp_payload_type        rsp_payload
);

   pidsi_pkg::cmd_type    cmd;
   pidsi_pkg::status_type sts;

   // sequencer: error, dead zone, ratio (divide), increment, four gain terms
   pidsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: 31x32 and 31x16 gain multiplies shared across terms, two passes per term
   pidsi_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sv/pidsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidsi_ctrl
// Sequencer: steps the datapath through one item, one operation a cycle.
// ----------------------------------------------------------------------------
module pidsi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pidsi_pkg::status_type sts,
   output pidsi_pkg::cmd_type    cmd
);

   pidsi_pkg::state_type state_ff, state_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [1:0]           term_ff, term_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidsi_pkg::S_IDLE;
         cnt_ff   <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         term_ff  <= term_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      term_in  = term_ff;
      unique case (state_ff)
         pidsi_pkg::S_IDLE:  if (req_valid) state_in = pidsi_pkg::S_ERR;
         pidsi_pkg::S_ERR:   state_in = sts.is_load ? pidsi_pkg::S_LOAD : pidsi_pkg::S_DZ;
         pidsi_pkg::S_DZ:    state_in = pidsi_pkg::S_RATIO;
         pidsi_pkg::S_RATIO: begin
            cnt_in   = '0;
            state_in = sts.need_div ? pidsi_pkg::S_DIV : pidsi_pkg::S_PROD;
         end
         pidsi_pkg::S_DIV: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(pidsi_pkg::DIV_STEPS - 1)) state_in = pidsi_pkg::S_PROD;
         end
         pidsi_pkg::S_PROD:  state_in = pidsi_pkg::S_INC;
         pidsi_pkg::S_INC: begin
            term_in  = pidsi_pkg::TERM_P;
            state_in = pidsi_pkg::S_MAG;
         end
         pidsi_pkg::S_MAG:   state_in = pidsi_pkg::S_MLO;
         pidsi_pkg::S_MLO:   state_in = pidsi_pkg::S_MHI;
         pidsi_pkg::S_MHI:   state_in = pidsi_pkg::S_TERM;
         pidsi_pkg::S_TERM:  state_in = pidsi_pkg::S_ACC;
         pidsi_pkg::S_ACC: begin
            term_in = term_ff + 2'd1;
            state_in = (term_ff == pidsi_pkg::TERM_F) ? pidsi_pkg::S_FIN
                                                       : pidsi_pkg::S_MAG;
         end
         pidsi_pkg::S_FIN:   state_in = pidsi_pkg::S_OUT;
         pidsi_pkg::S_LOAD:  state_in = pidsi_pkg::S_OUT;
         pidsi_pkg::S_OUT:   if (rsp_ready) state_in = pidsi_pkg::S_IDLE;
         default:            state_in = pidsi_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.term_sel = term_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         pidsi_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         pidsi_pkg::S_ERR:   cmd.do_err   = 1'b1;
         pidsi_pkg::S_DZ:    cmd.do_dz    = 1'b1;
         pidsi_pkg::S_RATIO: cmd.do_ratio = 1'b1;
         pidsi_pkg::S_DIV:   cmd.div_step = 1'b1;
         pidsi_pkg::S_PROD:  cmd.do_prod  = 1'b1;
         pidsi_pkg::S_INC:   cmd.do_inc   = 1'b1;
         pidsi_pkg::S_MAG:   cmd.do_mag   = 1'b1;
         pidsi_pkg::S_MLO:   cmd.do_mlo   = 1'b1;
         pidsi_pkg::S_MHI:   cmd.do_mhi   = 1'b1;
         pidsi_pkg::S_TERM:  cmd.do_term  = 1'b1;
         pidsi_pkg::S_ACC:   cmd.do_acc   = 1'b1;
         pidsi_pkg::S_FIN:   cmd.do_fin   = 1'b1;
         pidsi_pkg::S_LOAD:  cmd.do_load  = 1'b1;
         pidsi_pkg::S_OUT:   rsp_valid    = 1'b1;
         default:            cmd          = '0;
      endcase
   end

endmodule

// ===== sv/pidsi_dp.sv =====
// ----------------------------------------------------------------------------
// pidsi_dp
// Datapath: registers, state, restoring divider and shared gain multiplier.
// ----------------------------------------------------------------------------
module pidsi_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [pidsi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pidsi_pkg::CSR_W-1:0]              csr_data,
   input  pidsi_pkg::req_payload_type               req_payload,
   input  pidsi_pkg::cmd_type                       cmd,
   output pidsi_pkg::status_type                    sts,
   output pidsi_pkg::rsp_payload_type               rsp_payload
);

   // configuration
   logic [30:0] kp_ff, ki_ff, kd_ff, kf_ff;
   logic [62:0] lim_ff, ramp_ff;
   logic [46:0] ilim_ff;
   logic [31:0] sep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ki_ff <= '0; kd_ff <= '0; kf_ff <= '0;
         lim_ff <= '0; ramp_ff <= '0; ilim_ff <= '0; sep_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            pidsi_pkg::CSR_KP:       kp_ff   <= csr_data[30:0];
            pidsi_pkg::CSR_KI_DT:    ki_ff   <= csr_data[30:0];
            pidsi_pkg::CSR_KD_RATE:  kd_ff   <= csr_data[30:0];
            pidsi_pkg::CSR_KF:       kf_ff   <= csr_data[30:0];
            pidsi_pkg::CSR_LIMITS:   lim_ff  <= csr_data[62:0];
            pidsi_pkg::CSR_ILIMIT:   ilim_ff <= csr_data[46:0];
            pidsi_pkg::CSR_RAMP:     ramp_ff <= csr_data[62:0];
            pidsi_pkg::CSR_SEPARATE: sep_ff  <= csr_data[31:0];
            default:                 kp_ff   <= kp_ff;
         endcase
      end
   end

   // controller state
   logic signed [47:0] integ_ff, integ_in;
   logic signed [31:0] prev_err_ff, prev_tgt_ff, prev_meas_ff, last_drive_ff;

   // working registers
   pidsi_pkg::req_payload_type in_ff;
   logic signed [31:0] err_ff, eff_ff;
   logic [31:0]        abs_ff;
   logic [30:0]        rem_ff;
   logic [16:0]        ratio_ff;
   logic signed [32:0] din_ff, tdiff_ff;
   logic [48:0]        prod_ff;
   logic [47:0]        mag_ff;
   logic               neg_ff;
   logic [62:0]        plo_ff;
   logic [46:0]        phi_ff;
   logic signed [63:0] term_ff, total_ff;
   pidsi_pkg::rsp_payload_type out_ff;

   // combinational helpers
   logic signed [32:0] diff;
   logic signed [31:0] err_sat;
   logic [31:0]        abs_c;
   logic [30:0]        ra, rb, dz, thr, olim;
   logic [31:0]        sum_ab;
   logic               full_rate, in_ramp, sep_hit;
   logic [31:0]        div_t, div_sub;
   logic signed [49:0] inc, sum50;
   logic signed [48:0] v;
   logic [48:0]        vneg;
   logic [30:0]        gain;
   logic [79:0]        full;
   logic [63:0]        r, rcap;
   logic signed [63:0] tclamp;
   logic signed [31:0] drive_c;

   assign ra   = ramp_ff[62:32];
   assign rb   = ramp_ff[30:0];
   assign dz   = lim_ff[30:0];
   assign olim = lim_ff[62:32];
   assign thr  = sep_ff[30:0];

   always_comb begin
      diff    = 33'(in_ff.target) - 33'(in_ff.measured);
      if (diff > 33'sd2147483647)       err_sat = 32'sh7FFFFFFF;
      else if (diff < -33'sd2147483648) err_sat = 32'sh80000000;
      else                              err_sat = diff[31:0];
      abs_c     = err_ff[31] ? (~err_ff + 32'd1) : err_ff;
      sum_ab    = {1'b0, ra} + {1'b0, rb};
      full_rate = ((ra == '0) && (rb == '0)) || (abs_ff <= {1'b0, rb});
      in_ramp   = abs_ff < sum_ab;
      sep_hit   = (thr != '0) && (abs_ff >= {1'b0, thr});
      div_t     = {rem_ff, 1'b0};
      div_sub   = div_t - {1'b0, ra};
      inc       = err_ff[31] ? -$signed({17'd0, prod_ff[48:16]})
                             :  $signed({17'd0, prod_ff[48:16]});
      sum50     = 50'(integ_ff) + inc;
      unique case (cmd.term_sel)
         pidsi_pkg::TERM_P: begin v = 49'(err_ff);   gain = kp_ff; end
         pidsi_pkg::TERM_I: begin v = 49'(integ_ff); gain = ki_ff; end
         pidsi_pkg::TERM_D: begin v = 49'(din_ff);   gain = kd_ff; end
         pidsi_pkg::TERM_F: begin v = 49'(tdiff_ff); gain = kf_ff; end
         default:           begin v = '0;            gain = '0;    end
      endcase
      vneg   = -v;
      full   = {1'b0, phi_ff, 32'd0} + {17'd0, plo_ff};
      r      = full[79:16];
      rcap   = (r > 64'h1000_0000_0000_0000) ? 64'h1000_0000_0000_0000 : r;
      tclamp = total_ff;
      if (olim != '0) begin
         if (total_ff > $signed(64'(olim)))       tclamp = 64'(olim);
         else if (total_ff < -$signed(64'(olim))) tclamp = -64'(olim);
      end
      if (tclamp > 64'sd2147483647)       drive_c = 32'sh7FFFFFFF;
      else if (tclamp < -64'sd2147483648) drive_c = 32'sh80000000;
      else                                drive_c = tclamp[31:0];
   end

   // integral store next value
   always_comb begin
      integ_in = integ_ff;
      if (cmd.do_load) begin
         integ_in = in_ff.integral_value;
      end else if (cmd.do_ratio && (ilim_ff != '0)) begin
         if (integ_ff > $signed(48'(ilim_ff)))       integ_in = 48'(ilim_ff);
         else if (integ_ff < -$signed(48'(ilim_ff))) integ_in = -48'(ilim_ff);
      end else if (cmd.do_inc) begin
         if (sep_hit)                            integ_in = '0;
         else if (sum50 > 50'sh0_7FFF_FFFF_FFFF) integ_in = 48'sh7FFF_FFFF_FFFF;
         else if (sum50 < -50'sh0_8000_0000_0000) integ_in = 48'sh8000_0000_0000;
         else                                    integ_in = sum50[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         prev_err_ff   <= '0;
         prev_tgt_ff   <= '0;
         prev_meas_ff  <= '0;
         last_drive_ff <= '0;
      end else begin
         integ_ff <= integ_in;
         if (cmd.do_fin) begin
            prev_err_ff   <= err_ff;
            prev_tgt_ff   <= eff_ff;
            prev_meas_ff  <= in_ff.measured;
            last_drive_ff <= drive_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) in_ff <= req_payload;
      if (cmd.do_err) begin
         err_ff   <= err_sat;
         total_ff <= '0;
      end
      if (cmd.do_dz) begin
         if (abs_c < {1'b0, dz}) begin
            eff_ff <= in_ff.measured;
            err_ff <= '0;
            abs_ff <= '0;
         end else begin
            eff_ff <= in_ff.target;
            abs_ff <= abs_c;
         end
      end
      if (cmd.do_ratio) begin
         ratio_ff <= full_rate ? 17'h10000 : 17'd0;
         rem_ff   <= 31'(sum_ab - abs_ff);
         din_ff   <= sep_ff[31] ? (33'(prev_meas_ff) - 33'(in_ff.measured))
                                : (33'(err_ff) - 33'(prev_err_ff));
         tdiff_ff <= 33'(eff_ff) - 33'(prev_tgt_ff);
      end
      if (cmd.div_step) begin
         if (div_t >= {1'b0, ra}) begin
            rem_ff   <= div_sub[30:0];
            ratio_ff <= {1'b0, ratio_ff[14:0], 1'b1};
         end else begin
            rem_ff   <= div_t[30:0];
            ratio_ff <= {1'b0, ratio_ff[14:0], 1'b0};
         end
      end
      if (cmd.do_prod) prod_ff <= 49'(ratio_ff) * 49'(abs_ff);
      if (cmd.do_mag) begin
         neg_ff <= v[48];
         mag_ff <= v[48] ? vneg[47:0] : v[47:0];
      end
      if (cmd.do_mlo)  plo_ff <= 63'(gain) * 63'(mag_ff[31:0]);
      if (cmd.do_mhi)  phi_ff <= 47'(gain) * 47'(mag_ff[47:32]);
      if (cmd.do_term) term_ff <= neg_ff ? -$signed(rcap) : $signed(rcap);
      if (cmd.do_acc)  total_ff <= total_ff + term_ff;
      if (cmd.do_fin) begin
         out_ff.drive            <= drive_c;
         out_ff.effective_target <= eff_ff;
      end
      if (cmd.do_load) begin
         out_ff.drive            <= last_drive_ff;
         out_ff.effective_target <= prev_tgt_ff;
      end
   end

   assign sts.is_load  = (in_ff.req_type == pidsi_pkg::REQ_LOAD);
   assign sts.need_div = !full_rate && in_ramp;
   assign rsp_payload  = out_ff;

endmodule
